// File: src/tqls_pkg.sv
// ----------------------------------------------------------------------------
// tqls_pkg
// Shared types and constants of the tabular Q-learning step unit.
// ----------------------------------------------------------------------------
package tqls_pkg;

    // operation codes carried in s_tuser
    typedef enum logic [2:0] {
        OP_LOAD_EDGE  = 3'd0,
        OP_LOAD_VALUE = 3'd1,
        OP_LOAD_Q     = 3'd2,
        OP_START      = 3'd3,
        OP_STEP       = 3'd4
    } op_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_LEARN_RATE    = 3'd0,
        REG_DISCOUNT      = 3'd1,
        REG_REWARD_SCALE  = 3'd2,
        REG_MAX_VALUE     = 3'd3,
        REG_EXPLORE_LIMIT = 3'd4
    } reg_index_t;

    // configuration reset values
    localparam logic [15:0] LEARN_RATE_RST    = 16'd655;
    localparam logic [15:0] DISCOUNT_RST      = 16'd66;
    localparam logic [15:0] REWARD_SCALE_RST  = 16'd6554;
    localparam logic [15:0] MAX_VALUE_RST     = 16'd65535;
    localparam logic [15:0] EXPLORE_LIMIT_RST = 16'd64;

    // beat widths
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 80;

    // saturation bound of a Q16.16 value
    localparam logic [33:0] Q_LIMIT = 34'h0_FFFF_FFFF;

endpackage

// File: src/tabular_q_learning_step_unit.sv
// ----------------------------------------------------------------------------
// tabular_q_learning_step_unit
// Tabular Q-learning engine: loads a state graph, state values and Q values,
// then runs steps that update Q and pick the next action.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid/s_tready    tuser op, tdata load/step fields
//  m_*      out  m_tvalid/m_tready    tdata step result
//  cfg_*    in   cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
//  loads write their memory as the beat is taken; a step is a read of the current
//  row, a read of the reached row, then a chain of two multiplies and a saturating
//  update, all on simple dual-port memories with registered reads.
//  a start op sweeps the visit count memory, one row a cycle.
//  a stalled result holds the final step cycle until the output register frees.
//  reset clears control state and configuration; memories hold no reset.
// ----------------------------------------------------------------------------
module tabular_q_learning_step_unit #(
    parameter int STATES  = 64,
    parameter int ACTIONS = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // tuser: op[2:0]
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // tdata: state_index[5:0] action_index[7:6] edge_target[13:8]
    //        edge_present[14] cell_value[30:15] q_value[62:31] random_action[64:63]
    input  logic [tqls_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic [2:0]                      s_tuser,
    // tdata: next_state[5:0] next_action[7:6] reward[39:8] new_q[71:40]
    //        bad_move[72] explored[73]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tqls_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [2:0]                      cfg_index,
    input  logic [15:0]                     cfg_data
);

    localparam int SW = $clog2(STATES);
    localparam int AW = $clog2(ACTIONS);

    typedef logic [SW-1:0] state_wrap_t [64];
    typedef logic [AW-1:0] action_wrap_t [4];

    function automatic state_wrap_t build_state_wrap();
        state_wrap_t w;
        for (int i = 0; i < 64; i++)
        begin
            w[i] = SW'(i % STATES);
        end
        return w;
    endfunction

    function automatic action_wrap_t build_action_wrap();
        action_wrap_t w;
        for (int i = 0; i < 4; i++)
        begin
            w[i] = AW'(i % ACTIONS);
        end
        return w;
    endfunction

    localparam state_wrap_t  STATE_WRAP  = build_state_wrap();
    localparam action_wrap_t ACTION_WRAP = build_action_wrap();

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_FETCH,
        ST_ROW,
        ST_DISC,
        ST_ADJ,
        ST_NEWQ,
        ST_PICK
    } state_t;

    // input fields
    logic [SW-1:0] in_state;
    logic [AW-1:0] in_action;
    logic [SW-1:0] in_target;
    logic          in_present;
    logic [15:0]   in_value;
    logic [31:0]   in_q;
    logic [AW-1:0] in_random;
    logic          in_beat;

    assign in_state   = STATE_WRAP[s_tdata[5:0]];
    assign in_action  = ACTION_WRAP[s_tdata[7:6]];
    assign in_target  = STATE_WRAP[s_tdata[13:8]];
    assign in_present = s_tdata[14];
    assign in_value   = s_tdata[30:15];
    assign in_q       = s_tdata[62:31];
    assign in_random  = ACTION_WRAP[s_tdata[64:63]];
    assign in_beat    = s_tvalid && s_tready;

    // registers
    state_t        state_reg;
    logic [15:0]   learn_rate_reg, discount_reg, reward_scale_reg;
    logic [15:0]   max_value_reg, explore_limit_reg;
    logic [SW-1:0] cur_state_reg;
    logic [AW-1:0] cur_action_reg;
    logic          bad_flag_reg;
    logic [SW-1:0] clr_row_reg;
    logic [SW-1:0] s_new_reg;
    logic          bad_reg;
    logic [AW-1:0] random_reg;
    logic [31:0]   q_c_reg;
    logic [15:0]   cnt_inc_reg;
    logic [31:0]   q_row_reg [ACTIONS];
    logic          explore_reg;
    logic [31:0]   maxq_reg;
    logic [31:0]   reward_reg;
    logic [32:0]   target_reg;
    logic [32:0]   adj_reg;
    logic          neg_reg;
    logic [31:0]   nq_reg;
    logic          out_valid_reg;
    logic [tqls_pkg::OUT_DATA_W-1:0] out_data_reg;

    // memories and read registers
    logic [31:0]   q_mem   [STATES][ACTIONS];
    logic [15:0]   cnt_mem [STATES][ACTIONS];
    logic [SW:0]   edge_mem [STATES][ACTIONS];
    logic [15:0]   val_mem [STATES];
    logic [31:0]   q_rd   [ACTIONS];
    logic [15:0]   cnt_rd [ACTIONS];
    logic [SW:0]   edge_rd [ACTIONS];
    logic [15:0]   val_rd;

    logic [SW-1:0] rd_row;
    logic [SW:0]   edge_c;
    logic [SW-1:0] s_new;
    logic [15:0]   cnt_inc;
    logic          pick_go;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // final step cycle can hand over its result
    assign pick_go = (state_reg == ST_PICK) && (!out_valid_reg || m_tready);

    // read address: current row, then the reached row
    assign rd_row  = (state_reg == ST_FETCH) ? s_new : cur_state_reg;
    assign edge_c  = edge_rd[cur_action_reg];
    assign s_new   = edge_c[SW] ? edge_c[SW-1:0] : cur_state_reg;
    assign cnt_inc = (cnt_rd[cur_action_reg] == 16'hFFFF) ? 16'hFFFF
                                                          : cnt_rd[cur_action_reg] + 16'd1;

    // q memory
    always_ff @(posedge clk)
    begin
        if (in_beat && s_tuser == tqls_pkg::OP_LOAD_Q)
        begin
            q_mem[in_state][in_action] <= in_q;
        end
        else if (state_reg == ST_PICK)
        begin
            q_mem[cur_state_reg][cur_action_reg] <= nq_reg;
        end
        q_rd <= q_mem[rd_row];
    end

    // visit count memory
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
        begin
            for (int i = 0; i < ACTIONS; i++)
            begin
                cnt_mem[clr_row_reg][i] <= 16'd1;
            end
        end
        else if (state_reg == ST_FETCH)
        begin
            cnt_mem[cur_state_reg][cur_action_reg] <= cnt_inc;
        end
        cnt_rd <= cnt_mem[rd_row];
    end

    // edge and state value memories
    always_ff @(posedge clk)
    begin
        if (in_beat && s_tuser == tqls_pkg::OP_LOAD_EDGE)
        begin
            edge_mem[in_state][in_action] <= {in_present, in_target};
        end
        if (in_beat && s_tuser == tqls_pkg::OP_LOAD_VALUE)
        begin
            val_mem[in_state] <= in_value;
        end
        edge_rd <= edge_mem[rd_row];
        val_rd  <= val_mem[rd_row];
    end

    // reached row, with the just-written count forwarded when it is the current row
    logic [15:0] cnt_fwd [ACTIONS];
    logic        explore;
    logic [31:0] maxq;
    logic [31:0] reward;

    always_comb
    begin
        explore = 1'b0;
        maxq    = 32'd0;
        for (int i = 0; i < ACTIONS; i++)
        begin
            cnt_fwd[i] = (bad_reg && AW'(i) == cur_action_reg) ? cnt_inc_reg : cnt_rd[i];
            if (cnt_fwd[i] > explore_limit_reg)
            begin
                explore = 1'b1;
            end
            if (q_rd[i] > maxq)
            begin
                maxq = q_rd[i];
            end
        end
        if (bad_flag_reg || val_rd > max_value_reg)
        begin
            reward = 32'd0;
        end
        else
        begin
            reward = {16'd0, max_value_reg - val_rd} * {16'd0, reward_scale_reg};
        end
    end

    // discounted target
    logic [47:0] disc_prod;
    assign disc_prod = 48'(discount_reg) * 48'(maxq_reg);

    // scaled error
    logic signed [33:0] delta;
    logic [32:0]        mag;
    logic [48:0]        adj_prod;

    assign delta    = $signed({1'b0, target_reg}) - $signed({2'b00, q_c_reg});
    assign mag      = delta[33] ? 33'(-delta) : delta[32:0];
    assign adj_prod = 49'(mag) * 49'(learn_rate_reg);

    // saturating update
    logic [33:0] sum;
    logic [31:0] nq;

    assign sum = {2'b00, q_c_reg} + {1'b0, adj_reg};
    always_comb
    begin
        if (neg_reg)
        begin
            nq = (adj_reg > {1'b0, q_c_reg}) ? 32'd0 : 32'(sum - {adj_reg, 1'b0});
        end
        else
        begin
            nq = (sum > tqls_pkg::Q_LIMIT) ? 32'hFFFF_FFFF : sum[31:0];
        end
    end

    // argmax, first maximum wins
    logic [AW-1:0] amax;
    logic [AW-1:0] next_action;

    always_comb
    begin
        amax = '0;
        for (int i = 1; i < ACTIONS; i++)
        begin
            if (q_row_reg[i] > q_row_reg[amax])
            begin
                amax = AW'(i);
            end
        end
        next_action = explore_reg ? random_reg : amax;
    end

    // control and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            learn_rate_reg    <= tqls_pkg::LEARN_RATE_RST;
            discount_reg      <= tqls_pkg::DISCOUNT_RST;
            reward_scale_reg  <= tqls_pkg::REWARD_SCALE_RST;
            max_value_reg     <= tqls_pkg::MAX_VALUE_RST;
            explore_limit_reg <= tqls_pkg::EXPLORE_LIMIT_RST;
            cur_state_reg     <= '0;
            cur_action_reg    <= '0;
            bad_flag_reg      <= 1'b0;
            clr_row_reg       <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            // configuration writes
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    tqls_pkg::REG_LEARN_RATE:    learn_rate_reg    <= cfg_data;
                    tqls_pkg::REG_DISCOUNT:      discount_reg      <= cfg_data;
                    tqls_pkg::REG_REWARD_SCALE:  reward_scale_reg  <= cfg_data;
                    tqls_pkg::REG_MAX_VALUE:     max_value_reg     <= cfg_data;
                    tqls_pkg::REG_EXPLORE_LIMIT: explore_limit_reg <= cfg_data;
                    default: ;
                endcase
            end

            // result valid: set by the final step cycle, cleared by a taken beat
            if (pick_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tvalid && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_beat)
                    begin
                        random_reg <= in_random;
                        if (s_tuser == tqls_pkg::OP_START)
                        begin
                            cur_state_reg  <= in_state;
                            cur_action_reg <= '0;
                            bad_flag_reg   <= 1'b0;
                            clr_row_reg    <= '0;
                            state_reg      <= ST_CLEAR;
                        end
                        else if (s_tuser == tqls_pkg::OP_STEP)
                        begin
                            state_reg <= ST_FETCH;
                        end
                    end
                end
                ST_CLEAR:
                begin
                    clr_row_reg <= clr_row_reg + SW'(1);
                    if (clr_row_reg == SW'(STATES - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_FETCH:
                begin
                    s_new_reg   <= s_new;
                    bad_reg     <= (s_new == cur_state_reg);
                    q_c_reg     <= q_rd[cur_action_reg];
                    cnt_inc_reg <= cnt_inc;
                    state_reg   <= ST_ROW;
                end
                ST_ROW:
                begin
                    q_row_reg   <= q_rd;
                    explore_reg <= explore;
                    maxq_reg    <= maxq;
                    reward_reg  <= reward;
                    state_reg   <= ST_DISC;
                end
                ST_DISC:
                begin
                    target_reg <= {1'b0, reward_reg} + {1'b0, disc_prod[47:16]};
                    state_reg  <= ST_ADJ;
                end
                ST_ADJ:
                begin
                    adj_reg   <= adj_prod[48:16];
                    neg_reg   <= delta[33];
                    state_reg <= ST_NEWQ;
                end
                ST_NEWQ:
                begin
                    nq_reg <= nq;
                    if (bad_reg)
                    begin
                        q_row_reg[cur_action_reg] <= nq;
                    end
                    state_reg <= ST_PICK;
                end
                ST_PICK:
                begin
                    if (pick_go)
                    begin
                        out_data_reg   <= {6'd0, explore_reg, bad_reg, nq_reg, reward_reg,
                                           2'(next_action), 6'(s_new_reg)};
                        cur_state_reg  <= s_new_reg;
                        cur_action_reg <= next_action;
                        bad_flag_reg   <= bad_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // checks
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_PICK))
        else $error("result raised outside the final step cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && s_tuser == tqls_pkg::OP_STEP) |=> state_reg == ST_FETCH)
        else $error("step beat did not start a fetch");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> m_tdata[5:0] == 6'(cur_state_reg))
        else $error("current state differs from reported next state");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && s_tuser == tqls_pkg::OP_START) |=> clr_row_reg == '0 && !bad_flag_reg)
        else $error("start did not reset the sweep");

endmodule

// File: bench/tabular_q_learning_step_unit_test.sv
// ----------------------------------------------------------------------------
// tabular_q_learning_step_unit_test
// Self-checking bench for the Q-learning step unit: loads every table, runs a
// short directed sequence, then random load/start/step traffic under several
// register settings and idle patterns, checking each step result against an
// in-bench prediction of the engine.
// ----------------------------------------------------------------------------
module tabular_q_learning_step_unit_test;

    localparam int CELLS       = 256;
    localparam int QUIET_LIMIT = 5000;
    localparam int PHASE_ITEMS = 75;
    localparam int SETTLE      = 100;

    // one input beat, field by field
    typedef struct {
        logic [2:0]  op;
        logic [5:0]  state_index;
        logic [1:0]  action_index;
        logic [5:0]  edge_target;
        logic        edge_present;
        logic [15:0] cell_value;
        logic [31:0] q_value;
        logic [1:0]  random_action;
    } beat_t;

    // one step result
    typedef struct {
        logic [5:0]  next_state;
        logic [1:0]  next_action;
        logic [31:0] reward;
        logic [31:0] new_q;
        logic        bad_move;
        logic        explored;
    } step_result_t;

    // directed row: beat plus optional hand-typed result fields
    typedef struct {
        beat_t       b;
        bit          typed;
        logic [5:0]  next_state;
        logic [31:0] reward;
        logic        bad_move;
        logic        explored;
    } row_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [tqls_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic [2:0]                      s_tuser = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [tqls_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [2:0]                      cfg_index = '0;
    logic [15:0]                     cfg_data = '0;

    // engine state as the bench sees it
    logic [31:0] q_tab [CELLS];
    logic [15:0] visits [CELLS];
    logic [5:0]  edge_tgt [CELLS];
    logic        edge_on [CELLS];
    logic [15:0] state_val [64];
    logic [5:0]  cur_state = '0;
    logic [1:0]  cur_action = '0;
    logic        bad_prev = 1'b0;
    logic [15:0] lr = tqls_pkg::LEARN_RATE_RST;
    logic [15:0] disc = tqls_pkg::DISCOUNT_RST;
    logic [15:0] scale = tqls_pkg::REWARD_SCALE_RST;
    logic [15:0] max_v = tqls_pkg::MAX_VALUE_RST;
    logic [15:0] limit = tqls_pkg::EXPLORE_LIMIT_RST;

    step_result_t pending_results[$];
    int           errors = 0;
    int           idle_pct = 0;
    int           stall_pct = 0;
    int           hold_len = 0;
    int           quiet_cycles = 0;

    tabular_q_learning_step_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // one step of the engine: follow edge, reward, Q update, next action
    function automatic step_result_t run_step(logic [1:0] rand_act);
        step_result_t r;
        logic [7:0]   c;
        logic [5:0]   s;
        longint unsigned rw, mq, tgt, qv, adj, nq;
        logic [1:0]   amax;
        logic         expl;
        c = {cur_state, cur_action};
        s = edge_on[c] ? edge_tgt[c] : cur_state;
        if (visits[c] != 16'hFFFF)
            visits[c] = visits[c] + 16'd1;
        if (bad_prev || state_val[s] > max_v)
            rw = 0;
        else
            rw = 64'(max_v - state_val[s]) * 64'(scale);
        mq = 0;
        for (int i = 0; i < 4; i++)
            if (q_tab[{s, 2'(i)}] > mq)
                mq = 64'(q_tab[{s, 2'(i)}]);
        tgt = rw + ((64'(disc) * mq) >> 16);
        qv = 64'(q_tab[c]);
        if (tgt >= qv)
            nq = qv + (((tgt - qv) * 64'(lr)) >> 16);
        else
        begin
            adj = ((qv - tgt) * 64'(lr)) >> 16;
            nq = (adj > qv) ? 0 : qv - adj;
        end
        if (nq > 64'hFFFF_FFFF)
            nq = 64'hFFFF_FFFF;
        q_tab[c] = nq[31:0];
        expl = 1'b0;
        amax = 2'd0;
        for (int i = 0; i < 4; i++)
        begin
            if (visits[{s, 2'(i)}] > limit)
                expl = 1'b1;
            if (q_tab[{s, 2'(i)}] > q_tab[{s, amax}])
                amax = 2'(i);
        end
        r.next_state = s;
        r.next_action = expl ? rand_act : amax;
        r.reward = rw[31:0];
        r.new_q = nq[31:0];
        r.bad_move = (s == cur_state);
        r.explored = expl;
        bad_prev = r.bad_move;
        cur_state = s;
        cur_action = r.next_action;
        return r;
    endfunction

    // apply an accepted beat to the bench copy of the engine
    task automatic absorb_beat(beat_t b);
        case (b.op)
            tqls_pkg::OP_LOAD_EDGE:
            begin
                edge_tgt[{b.state_index, b.action_index}] = b.edge_target;
                edge_on[{b.state_index, b.action_index}] = b.edge_present;
            end
            tqls_pkg::OP_LOAD_VALUE: state_val[b.state_index] = b.cell_value;
            tqls_pkg::OP_LOAD_Q:     q_tab[{b.state_index, b.action_index}] = b.q_value;
            tqls_pkg::OP_START:
            begin
                cur_state = b.state_index;
                cur_action = 2'd0;
                bad_prev = 1'b0;
                for (int i = 0; i < CELLS; i++)
                    visits[i] = 16'd1;
            end
            tqls_pkg::OP_STEP:       pending_results.push_back(run_step(b.random_action));
            default: ;
        endcase
    endtask

    // offer one beat, idling at random first, and wait for its acceptance
    task automatic send_beat(beat_t b);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= b.op;
        s_tdata <= {7'd0, b.random_action, b.q_value, b.cell_value, b.edge_present,
                    b.edge_target, b.action_index, b.state_index};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        absorb_beat(b);
    endtask

    // offer one register write; the caller drops cfg_valid after the last one
    task automatic write_reg(tqls_pkg::reg_index_t idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            tqls_pkg::REG_LEARN_RATE:    lr = val;
            tqls_pkg::REG_DISCOUNT:      disc = val;
            tqls_pkg::REG_REWARD_SCALE:  scale = val;
            tqls_pkg::REG_MAX_VALUE:     max_v = val;
            tqls_pkg::REG_EXPLORE_LIMIT: limit = val;
            default: ;
        endcase
    endtask

    // stop offering, wait for every result, then let loads and sweeps finish
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_q();
        case ($urandom_range(3))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom_range(32'h0003_FFFF);
            default: return $urandom;
        endcase
    endfunction

    function automatic beat_t random_beat();
        beat_t b;
        int    r;
        r = $urandom_range(99);
        b.state_index = 6'($urandom_range(63));
        b.action_index = 2'($urandom_range(3));
        b.edge_target = 6'($urandom_range(63));
        b.edge_present = ($urandom_range(9) < 8);
        b.cell_value = 16'($urandom_range(65535));
        b.q_value = pick_q();
        b.random_action = 2'($urandom_range(3));
        if (r < 72)
            b.op = tqls_pkg::OP_STEP;
        else if (r < 80)
            b.op = tqls_pkg::OP_LOAD_EDGE;
        else if (r < 87)
            b.op = tqls_pkg::OP_LOAD_VALUE;
        else if (r < 94)
            b.op = tqls_pkg::OP_LOAD_Q;
        else if (r < 97)
            b.op = tqls_pkg::OP_START;
        else
            b.op = 3'($urandom_range(7, 5));
        return b;
    endfunction

    function automatic beat_t mk(logic [2:0] op, logic [5:0] si, logic [1:0] ai,
                                 logic [5:0] tg, logic pr, logic [15:0] v,
                                 logic [31:0] q, logic [1:0] ra);
        beat_t b;
        b.op = op;
        b.state_index = si;
        b.action_index = ai;
        b.edge_target = tg;
        b.edge_present = pr;
        b.cell_value = v;
        b.q_value = q;
        b.random_action = ra;
        return b;
    endfunction

    // result side: check each beat, then decide ready for the next edge
    always @(posedge clk)
    begin
        step_result_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.next_state = m_tdata[5:0];
            got.next_action = m_tdata[7:6];
            got.reward = m_tdata[39:8];
            got.new_q = m_tdata[71:40];
            got.bad_move = m_tdata[72];
            got.explored = m_tdata[73];
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing expected");
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.next_state !== want.next_state)
                begin
                    $error("next_state: expected %0d, got %0d", want.next_state, got.next_state);
                    errors++;
                end
                if (got.next_action !== want.next_action)
                begin
                    $error("next_action: expected %0d, got %0d",
                           want.next_action, got.next_action);
                    errors++;
                end
                if (got.reward !== want.reward)
                begin
                    $error("reward: expected %h, got %h", want.reward, got.reward);
                    errors++;
                end
                if (got.new_q !== want.new_q)
                begin
                    $error("new_q: expected %h, got %h", want.new_q, got.new_q);
                    errors++;
                end
                if (got.bad_move !== want.bad_move)
                begin
                    $error("bad_move: expected %b, got %b", want.bad_move, got.bad_move);
                    errors++;
                end
                if (got.explored !== want.explored)
                begin
                    $error("explored: expected %b, got %b", want.explored, got.explored);
                    errors++;
                end
            end
        end
        if (hold_len > 0)
        begin
            hold_len--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        row_t        rows[$];
        row_t        rw;
        logic [15:0] setting [5];

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every table, then start
        for (int i = 0; i < CELLS; i++)
        begin
            send_beat(mk(tqls_pkg::OP_LOAD_EDGE, i[7:2], i[1:0], 6'($urandom_range(63)),
                         ($urandom_range(9) < 8), 16'd0, 32'd0, 2'd0));
            send_beat(mk(tqls_pkg::OP_LOAD_Q, i[7:2], i[1:0], 6'd0, 1'b0, 16'd0,
                         pick_q(), 2'd0));
        end
        for (int i = 0; i < 64; i++)
            send_beat(mk(tqls_pkg::OP_LOAD_VALUE, i[5:0], 2'd0, 6'd0, 1'b0,
                         16'($urandom_range(65535)), 32'd0, 2'd0));
        send_beat(mk(tqls_pkg::OP_START, 6'd0, 2'd0, 6'd0, 1'b0, 16'd0, 32'd0, 2'd0));

        // directed rows at reset settings
        rw.typed = 1'b0;
        rw.b = mk(tqls_pkg::OP_LOAD_EDGE, 6'd1, 2'd0, 6'd2, 1'b1, 16'd0, 32'd0, 2'd0);
        rows.push_back(rw);
        rw.b = mk(tqls_pkg::OP_LOAD_EDGE, 6'd2, 2'd0, 6'd63, 1'b0, 16'd0, 32'd0, 2'd0);
        rows.push_back(rw);
        rw.b = mk(tqls_pkg::OP_LOAD_VALUE, 6'd2, 2'd0, 6'd0, 1'b0, 16'hFFFF, 32'd0, 2'd0);
        rows.push_back(rw);
        for (int a = 0; a < 4; a++)
        begin
            rw.b = mk(tqls_pkg::OP_LOAD_Q, 6'd2, 2'(a), 6'd0, 1'b0, 16'd0, 32'd0, 2'd0);
            rows.push_back(rw);
        end
        rw.b = mk(tqls_pkg::OP_LOAD_Q, 6'd1, 2'd0, 6'd0, 1'b0, 16'd0, 32'hFFFF_FFFF, 2'd0);
        rows.push_back(rw);
        rw.b = mk(tqls_pkg::OP_START, 6'd1, 2'd0, 6'd0, 1'b0, 16'd0, 32'd0, 2'd0);
        rows.push_back(rw);
        // edge taken, state value at maximum gives no reward
        rw.typed = 1'b1; rw.next_state = 6'd2; rw.reward = 32'd0;
        rw.bad_move = 1'b0; rw.explored = 1'b0;
        rw.b = mk(tqls_pkg::OP_STEP, 6'd0, 2'd0, 6'd0, 1'b0, 16'd0, 32'd0, 2'd3);
        rows.push_back(rw);
        // missing edge: stay put, bad move
        rw.bad_move = 1'b1;
        rw.b = mk(tqls_pkg::OP_STEP, 6'd0, 2'd0, 6'd0, 1'b0, 16'd0, 32'd0, 2'd3);
        rows.push_back(rw);
        rw.typed = 1'b0;
        rw.b = mk(tqls_pkg::OP_LOAD_VALUE, 6'd2, 2'd0, 6'd0, 1'b0, 16'd0, 32'd0, 2'd0);
        rows.push_back(rw);
        // reward forced to zero right after a bad move
        rw.typed = 1'b1;
        rw.b = mk(tqls_pkg::OP_STEP, 6'd0, 2'd0, 6'd0, 1'b0, 16'd0, 32'd0, 2'd0);
        rows.push_back(rw);
        rw.typed = 1'b0;
        rw.b = mk(tqls_pkg::OP_START, 6'd1, 2'd0, 6'd0, 1'b0, 16'd0, 32'd0, 2'd0);
        rows.push_back(rw);
        // full reward: max_value times scale
        rw.typed = 1'b1; rw.bad_move = 1'b0; rw.reward = 32'd429516390;
        rw.b = mk(tqls_pkg::OP_STEP, 6'd0, 2'd0, 6'd0, 1'b0, 16'd0, 32'd0, 2'd0);
        rows.push_back(rw);
        rw.typed = 1'b0;
        // unused op codes are ignored
        for (int k = 5; k < 8; k++)
        begin
            rw.b = mk(3'(k), 6'd63, 2'd3, 6'd63, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 2'd3);
            rows.push_back(rw);
        end
        rw.b = mk(tqls_pkg::OP_LOAD_EDGE, 6'd63, 2'd3, 6'd63, 1'b1, 16'd0, 32'd0, 2'd0);
        rows.push_back(rw);
        rw.b = mk(tqls_pkg::OP_LOAD_Q, 6'd63, 2'd3, 6'd0, 1'b0, 16'd0, 32'hFFFF_FFFF, 2'd0);
        rows.push_back(rw);
        rw.b = mk(tqls_pkg::OP_STEP, 6'd0, 2'd0, 6'd0, 1'b0, 16'd0, 32'd0, 2'd3);
        rows.push_back(rw);
        rw.b = mk(tqls_pkg::OP_STEP, 6'd0, 2'd0, 6'd0, 1'b0, 16'd0, 32'd0, 2'd1);
        rows.push_back(rw);

        foreach (rows[i])
        begin
            send_beat(rows[i].b);
            if (rows[i].typed)
            begin
                pending_results[$].next_state = rows[i].next_state;
                pending_results[$].reward = rows[i].reward;
                pending_results[$].bad_move = rows[i].bad_move;
                pending_results[$].explored = rows[i].explored;
            end
        end
        drain();

        // random phases, each under its own settings and idle pattern
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: setting = '{tqls_pkg::LEARN_RATE_RST, tqls_pkg::DISCOUNT_RST,
                               tqls_pkg::REWARD_SCALE_RST, tqls_pkg::MAX_VALUE_RST,
                               tqls_pkg::EXPLORE_LIMIT_RST};
                1: setting = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
                2: setting = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
                default:
                    for (int k = 0; k < 5; k++)
                        setting[k] = 16'($urandom_range(65535));
            endcase
            if (ph >= 3)
                setting[tqls_pkg::REG_EXPLORE_LIMIT] = 16'($urandom_range(40));
            for (int k = 0; k < 5; k++)
                write_reg(tqls_pkg::reg_index_t'(k), setting[k]);
            cfg_valid <= 1'b0;
            case (ph)
                1, 5:    begin idle_pct = 82; stall_pct = 0;  end
                2, 6:    begin idle_pct = 0;  stall_pct = 82; end
                3, 7:    begin idle_pct = 37; stall_pct = 37; end
                default: begin idle_pct = 0;  stall_pct = 0;  end
            endcase
            // long receiver hold-off while the sender keeps pushing
            if (ph == 4)
                hold_len = 400;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_beat(random_beat());
            drain();
        end

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
